// ----- rtl/rmv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmv_pkg: shared types and constants of the rtt mean/variance tracker
// Table geometry, field widths, codes and small helpers.
// ----------------------------------------------------------------------------
package rmv_pkg;

   localparam int ENTRIES     = 64;
   localparam int IDX_W       = $clog2(ENTRIES);
   localparam int SLOT_W      = 6;
   localparam int TIME_W      = 32;
   localparam int RTT_BITS    = 16;
   localparam int RTT_W       = 16;
   localparam int MEAN_W      = 24;
   localparam int VAR_W       = 40;
   localparam int COUNT_W     = 16;
   localparam int FACTOR_W    = 8;
   localparam int STATS_W     = MEAN_W + VAR_W + COUNT_W;
   localparam int DEN_W       = COUNT_W + 1;
   localparam int MUL_W       = 24;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int ACC_W       = 57;
   localparam int DIV_NUM_W   = 57;
   localparam int DIV_Q_W     = 41;
   localparam int MEAN_Q_W    = 25;
   localparam int DIV_CNT_W   = 6;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int PADDR_W     = 3;
   localparam int DATA_W      = 32;

   localparam logic [TIME_W-1:0] RTT_MAX   = TIME_W'((64'd1 << RTT_BITS) - 64'd1);
   localparam logic [TIME_W-1:0] X_CLAMP   = TIME_W'({RTT_W{1'b1}});
   localparam logic [DEN_W-1:0]  COUNT_WRAP = DEN_W'(65535);

   localparam logic [0:0] REG_OUTLIER_FACTOR = 1'b0;
   localparam logic [0:0] REG_WARMUP         = 1'b1;

   localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(4);
   localparam logic [COUNT_W-1:0]  WARMUP_RESET = COUNT_W'(10);

   typedef enum logic [1:0] {
      KIND_SEND   = 2'd0,
      KIND_ARRIVE = 2'd1,
      KIND_DELETE = 2'd2,
      KIND_QUERY  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_SEND   = 2'd1,
      STATUS_REJECT    = 2'd2,
      STATUS_NO_RECORD = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_EVAL, S_FV0, S_FV1, S_DD, S_CMP, S_MN,
      S_MNW, S_DIVM, S_P, S_NV0, S_NV1, S_NVW, S_DIVV, S_DONE
   } state_type;

   typedef struct packed {
      kind_type          kind;
      logic [IDX_W-1:0]  slot;
      logic [TIME_W-1:0] now;
   } item_type;

   typedef struct packed {
      logic [FACTOR_W-1:0] factor;
      logic [COUNT_W-1:0]  warmup;
   } cfg_type;

   typedef struct packed {
      logic [MEAN_W-1:0]  mean;
      logic [VAR_W-1:0]   variance;
      logic [COUNT_W-1:0] count;
   } stats_type;

   typedef struct packed {
      status_type         status;
      logic [RTT_W-1:0]   rtt;
      logic [MEAN_W-1:0]  mean;
      logic [VAR_W-1:0]   variance;
      logic [COUNT_W-1:0] count;
   } result_type;

   function automatic logic [MUL_W-1:0] absdiff(input logic [MUL_W-1:0] a,
                                                input logic [MUL_W-1:0] b);
      absdiff = (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

// ----- rtl/rmv_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmv_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rmv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/rmv_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmv_div: bit-serial restoring divider
// One quotient bit per cycle; 25 bits for the mean, 41 for the variance.
// ----------------------------------------------------------------------------
module rmv_div
   import rmv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 var_mode,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DEN_W-1:0]     den,
   output logic                 done,
   output logic [DIV_Q_W-1:0]   quot
);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DIV_Q_W-1:0]   bits_ff, bits_in;
   logic [DIV_Q_W-1:0]   quot_ff, quot_in;
   logic [DEN_W:0]       trial;
   logic                 qbit;

   // the numerator is below den << qbits, so its top part is already a remainder
   assign trial = {rem_ff, bits_ff[DIV_Q_W-1]};
   assign qbit  = (trial >= {1'b0, den});

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      bits_in = bits_ff;
      quot_in = quot_ff;
      if (start) begin
         run_in  = 1'b1;
         quot_in = '0;
         if (var_mode) begin
            rem_in  = DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
            bits_in = num[DIV_Q_W-1:0];
            cnt_in  = DIV_CNT_W'(DIV_Q_W);
         end else begin
            rem_in  = DEN_W'(num[DIV_Q_W-1:MEAN_Q_W]);
            bits_in = {num[MEAN_Q_W-1:0], (DIV_Q_W - MEAN_Q_W)'(0)};
            cnt_in  = DIV_CNT_W'(MEAN_Q_W);
         end
      end else if (run_ff) begin
         rem_in  = qbit ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
         bits_in = {bits_ff[DIV_Q_W-2:0], 1'b0};
         quot_in = {quot_ff[DIV_Q_W-2:0], qbit};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ----- rtl/rmv_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmv_front: request intake and classification
// Decodes kind, folds slot into the table, buffers words in a short queue.
// ----------------------------------------------------------------------------
module rmv_front
   import rmv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_kind,
   input  logic [SLOT_W-1:0] req_slot,
   input  logic [TIME_W-1:0] req_now,
   output item_type          q_item,
   output logic              q_valid,
   input  logic              q_pop
);

   item_type           slots_ff [QUEUE_DEPTH];
   item_type           in_item;
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               full, push, pop;

   assign in_item.kind = kind_type'(req_kind);
   assign in_item.slot = IDX_W'(32'(req_slot) % ENTRIES);
   assign in_item.now  = req_now;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign req_stall = full;
   assign push      = req_valid && !full;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_item    = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slots_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ----- rtl/rmv_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmv_back: slot table and statistics sequencer
// Reads a slot, runs the update on one shared multiplier and the divider.
// ----------------------------------------------------------------------------
module rmv_back
   import rmv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  item_type   q_item,
   input  logic       q_valid,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_res
);

   state_type            state_ff, state_in;
   item_type             item_ff;
   logic [ENTRIES-1:0]   send_valid_ff, record_valid_ff;
   logic                 cur_sv_ff, cur_rv_ff;
   logic [TIME_W-1:0]    time_ff;
   logic [MEAN_W-1:0]    m_ff, x_ff, newm_ff;
   logic [VAR_W-1:0]     v_ff;
   logic [COUNT_W-1:0]   n_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [ACC_W-1:0]     acc_ff;
   result_type           res_ff;
   result_type           rsp_res_ff;
   logic                 rsp_valid_ff;

   logic [TIME_W-1:0]    time_rdata;
   stats_type            stats_rdata;
   logic                 time_we, stats_we;
   stats_type            stats_wdata;

   logic [MUL_W-1:0]     mul_a, mul_b;
   logic                 div_start, div_var, div_done;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_Q_W-1:0]   div_quot;

   logic [DEN_W-1:0]     den;
   logic [COUNT_W-1:0]   half;
   logic [MUL_W-1:0]     d_xm, d_xn;
   logic [TIME_W-1:0]    delta, delta_sat;
   logic [RTT_W-1:0]     rtt_val;
   logic [MEAN_W-1:0]    x_val;
   logic                 reject, warm, out_free;
   logic [VAR_W-1:0]     newv;
   logic [COUNT_W-1:0]   new_cnt;
   logic [VAR_W-1:0]     pq8;
   result_type           eval_res;

   rmv_ram #(.WIDTH(TIME_W), .DEPTH(ENTRIES)) u_time_ram (
      .clock (clock),
      .we    (time_we),
      .waddr (item_ff.slot),
      .wdata (item_ff.now),
      .raddr (q_item.slot),
      .rdata (time_rdata)
   );

   rmv_ram #(.WIDTH(STATS_W), .DEPTH(ENTRIES)) u_stats_ram (
      .clock (clock),
      .we    (stats_we),
      .waddr (item_ff.slot),
      .wdata (stats_wdata),
      .raddr (q_item.slot),
      .rdata (stats_rdata)
   );

   rmv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .var_mode (div_var),
      .num      (div_num),
      .den      (den),
      .done     (div_done),
      .quot     (div_quot)
   );

   // ---- datapath helpers
   assign den       = {1'b0, n_ff} + DEN_W'(1);
   assign half      = den[DEN_W-1:1];
   assign d_xm      = absdiff(x_ff, m_ff);
   assign d_xn      = absdiff(x_ff, newm_ff);
   assign delta     = item_ff.now - time_ff;
   assign delta_sat = (delta > RTT_MAX) ? RTT_MAX : delta;
   assign rtt_val   = delta_sat[RTT_W-1:0];
   assign x_val     = {((delta_sat > X_CLAMP) ? {RTT_W{1'b1}} : delta_sat[RTT_W-1:0]), 8'h00};
   // squared deviation (Q32.16) against factor * variance moved to Q40.16
   assign reject    = {8'h00, prod_ff} > {acc_ff[PROD_W-1:0], 8'h00};
   assign warm      = (n_ff >= cfg.warmup);
   assign newv      = div_quot[DIV_Q_W-1] ? {VAR_W{1'b1}} : div_quot[VAR_W-1:0];
   assign new_cnt   = (den >= COUNT_WRAP) ? COUNT_W'(1) : den[COUNT_W-1:0];
   assign pq8       = VAR_W'((prod_ff + PROD_W'(128)) >> 8);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // ---- result word as classified in S_EVAL
   always_comb begin
      eval_res.status   = cur_rv_ff ? STATUS_OK : STATUS_NO_RECORD;
      eval_res.rtt      = '0;
      eval_res.mean     = cur_rv_ff ? m_ff : '0;
      eval_res.variance = cur_rv_ff ? v_ff : '0;
      eval_res.count    = cur_rv_ff ? n_ff : '0;
      case (item_ff.kind)
         KIND_SEND: eval_res.status = STATUS_OK;
         KIND_DELETE: begin
            eval_res.mean     = '0;
            eval_res.variance = '0;
            eval_res.count    = '0;
         end
         KIND_ARRIVE: begin
            if (!cur_sv_ff) begin
               eval_res.status = STATUS_NO_SEND;
            end else begin
               eval_res.status = STATUS_OK;
               eval_res.rtt    = rtt_val;
               if (!cur_rv_ff) begin
                  // first sample seeds the slot
                  eval_res.mean     = x_val;
                  eval_res.variance = '0;
                  eval_res.count    = COUNT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // ---- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) state_in = S_READ;
         end
         S_READ: state_in = S_EVAL;
         S_EVAL: begin
            if (item_ff.kind != KIND_ARRIVE || !cur_sv_ff || !cur_rv_ff) begin
               state_in = S_DONE;
            end else if (warm) begin
               state_in = S_FV0;
            end else begin
               state_in = S_MN;
            end
         end
         S_FV0: state_in = S_FV1;
         S_FV1: state_in = S_DD;
         S_DD:  state_in = S_CMP;
         S_CMP: state_in = reject ? S_DONE : S_MN;
         S_MN:  state_in = S_MNW;
         S_MNW: state_in = S_DIVM;
         S_DIVM: begin
            if (div_done) state_in = S_P;
         end
         S_P:   state_in = S_NV0;
         S_NV0: state_in = S_NV1;
         S_NV1: state_in = S_NVW;
         S_NVW: state_in = S_DIVV;
         S_DIVV: begin
            if (div_done) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---- control outputs
   always_comb begin
      q_pop       = 1'b0;
      time_we     = 1'b0;
      stats_we    = 1'b0;
      stats_wdata = '{mean: x_val, variance: '0, count: COUNT_W'(1)};
      mul_a       = '0;
      mul_b       = '0;
      div_start   = 1'b0;
      div_var     = 1'b0;
      div_num     = DIV_NUM_W'(ACC_W'(prod_ff[39:0]) + ACC_W'(x_ff) + ACC_W'(half));
      case (state_ff)
         S_IDLE: q_pop = q_valid;
         S_EVAL: begin
            time_we  = (item_ff.kind == KIND_SEND);
            stats_we = (item_ff.kind == KIND_ARRIVE) && cur_sv_ff && !cur_rv_ff;
         end
         S_FV0: begin
            mul_a = MUL_W'(cfg.factor);
            mul_b = v_ff[23:0];
         end
         S_FV1: begin
            mul_a = MUL_W'(cfg.factor);
            mul_b = MUL_W'(v_ff[VAR_W-1:24]);
         end
         S_DD: begin
            mul_a = d_xm;
            mul_b = d_xm;
         end
         S_MN: begin
            mul_a = m_ff;
            mul_b = MUL_W'(n_ff);
         end
         S_MNW: div_start = 1'b1;
         S_P: begin
            mul_a = d_xm;
            mul_b = d_xn;
         end
         S_NV0: begin
            mul_a = MUL_W'(n_ff);
            mul_b = v_ff[23:0];
         end
         S_NV1: begin
            mul_a = MUL_W'(n_ff);
            mul_b = MUL_W'(v_ff[VAR_W-1:24]);
         end
         S_NVW: begin
            div_start = 1'b1;
            div_var   = 1'b1;
            div_num   = acc_ff + {1'b0, prod_ff[31:0], 24'h000000} + ACC_W'(half);
         end
         S_DIVV: begin
            stats_we    = div_done;
            stats_wdata = '{mean: newm_ff, variance: newv, count: new_cnt};
         end
         default: begin
         end
      endcase
   end

   // ---- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         send_valid_ff   <= '0;
         record_valid_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_EVAL) begin
            case (item_ff.kind)
               KIND_SEND:   send_valid_ff[item_ff.slot] <= 1'b1;
               KIND_DELETE: record_valid_ff[item_ff.slot] <= 1'b0;
               KIND_ARRIVE: begin
                  if (cur_sv_ff) record_valid_ff[item_ff.slot] <= 1'b1;
               end
               default: begin
               end
            endcase
         end
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---- datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) item_ff <= q_item;
         end
         S_READ: begin
            time_ff   <= time_rdata;
            m_ff      <= stats_rdata.mean;
            v_ff      <= stats_rdata.variance;
            n_ff      <= stats_rdata.count;
            cur_sv_ff <= send_valid_ff[item_ff.slot];
            cur_rv_ff <= record_valid_ff[item_ff.slot];
         end
         S_EVAL: begin
            x_ff   <= x_val;
            res_ff <= eval_res;
         end
         S_FV1: acc_ff <= ACC_W'(prod_ff);
         S_DD:  acc_ff <= acc_ff + {9'h000, prod_ff[23:0], 24'h000000};
         S_CMP: begin
            if (reject) res_ff.status <= STATUS_REJECT;
         end
         S_DIVM: begin
            if (div_done) newm_ff <= div_quot[MEAN_W-1:0];
         end
         S_NV0: acc_ff <= ACC_W'(pq8);
         S_NV1: acc_ff <= acc_ff + ACC_W'(prod_ff);
         S_DIVV: begin
            if (div_done) begin
               res_ff.mean     <= newm_ff;
               res_ff.variance <= newv;
               res_ff.count    <= new_cnt;
            end
         end
         S_DONE: begin
            if (out_free) rsp_res_ff <= res_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_res   = rsp_res_ff;

endmodule

// ----- rtl/rtt_mean_variance_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtt_mean_variance_tracker: per-slot round-trip mean and variance
// Send, arrive, delete and query words over a 64-slot peer table.
// ----------------------------------------------------------------------------
// Steps: send, delete, query and arrive without history pass IDLE, READ, EVAL and DONE
// to the result register; an arrive that updates history also runs the bit-serial divider
// twice (mean, then variance) and skips the outlier check while below the warm-up count.
// Throughput: one word at a time in the back end; a 2-word queue keeps accepting until full.
// Reset (synchronous): clears queue, send/record valid bits, output valid and
// sets outlier_factor=4, warmup_samples=10. The slot RAMs need no clearing.
module rtt_mean_variance_tracker
   import rmv_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request words
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [SLOT_W-1:0]  req_slot,
   input  logic [TIME_W-1:0]  req_now,
   // result words
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [RTT_W-1:0]   rsp_rtt,
   output logic [MEAN_W-1:0]  rsp_mean_q8,
   output logic [VAR_W-1:0]   rsp_variance_q8,
   output logic [COUNT_W-1:0] rsp_sample_count,
   // register port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [PADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0]  csr_pwdata,
   output logic [DATA_W-1:0]  csr_prdata,
   output logic               csr_pready
);

   cfg_type    cfg_ff, cfg_in;
   logic       csr_wr;
   item_type   q_item;
   logic       q_valid, q_pop;
   result_type rsp_res;

   // ---- registers: outlier_factor at 0x0, warmup_samples at 0x4
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_OUTLIER_FACTOR: cfg_in.factor = csr_pwdata[FACTOR_W-1:0];
            REG_WARMUP:         cfg_in.warmup = csr_pwdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_OUTLIER_FACTOR: csr_prdata = DATA_W'(cfg_ff.factor);
         REG_WARMUP:         csr_prdata = DATA_W'(cfg_ff.warmup);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.factor <= FACTOR_RESET;
         cfg_ff.warmup <= WARMUP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---- front: intake, kind decode, slot fold, queue
   rmv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .req_slot  (req_slot),
      .req_now   (req_now),
      .q_item    (q_item),
      .q_valid   (q_valid),
      .q_pop     (q_pop)
   );

   // ---- back: slot table, Welford update, output register
   rmv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_item    (q_item),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_res   (rsp_res)
   );

   assign rsp_status       = rsp_res.status;
   assign rsp_rtt          = rsp_res.rtt;
   assign rsp_mean_q8      = rsp_res.mean;
   assign rsp_variance_q8  = rsp_res.variance;
   assign rsp_sample_count = rsp_res.count;

`ifndef SYNTHESIS
   // back end only pulls from a non-empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   // no result word right out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a warm-up write lands in the register
   a_warmup_write: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_paddr[2] == REG_WARMUP) |=> cfg_ff.warmup == $past(csr_pwdata[15:0]))
      else $error("warm-up register write lost");
`endif

endmodule

// ----- dv/rtt_mean_variance_tracker_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtt_mean_variance_tracker_tb: self-checking bench for the rtt tracker
// Drives send/arrive/delete/query words with random idling on both channels,
// predicts every result word from a local Welford model of the slot table and
// compares field by field. Runs under several outlier/warm-up settings.
// ----------------------------------------------------------------------------
module rtt_mean_variance_tracker_tb;
   import rmv_pkg::*;

   // register byte addresses (4 bytes per register)
   localparam logic [PADDR_W-1:0] ADDR_FACTOR = {REG_OUTLIER_FACTOR, 2'b00};
   localparam logic [PADDR_W-1:0] ADDR_WARMUP = {REG_WARMUP, 2'b00};

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_kind;
   logic [SLOT_W-1:0]  req_slot;
   logic [TIME_W-1:0]  req_now;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_status;
   logic [RTT_W-1:0]   rsp_rtt;
   logic [MEAN_W-1:0]  rsp_mean_q8;
   logic [VAR_W-1:0]   rsp_variance_q8;
   logic [COUNT_W-1:0] rsp_sample_count;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [PADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0]  csr_pwdata;
   logic [DATA_W-1:0]  csr_prdata;
   logic               csr_pready;

   rtt_mean_variance_tracker u_dut (.*);

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // local copy of the slot table and registers
   // ---------------------------------------------------------------------
   logic [FACTOR_W-1:0] cur_factor;
   logic [COUNT_W-1:0]  cur_warmup;
   logic [TIME_W-1:0]   ping_time [ENTRIES];
   bit                  ping_ok   [ENTRIES];
   logic [MEAN_W-1:0]   avg_q8    [ENTRIES];
   logic [VAR_W-1:0]    spread_q8 [ENTRIES];
   logic [COUNT_W-1:0]  samples   [ENTRIES];
   bit                  has_stats [ENTRIES];
   int unsigned         rtt_base  [ENTRIES];   // per-slot typical rtt for stimulus

   result_type expected_words[$];
   int         errors = 0;
   bit         quiet  = 1'b0;    // no idling on either side while set

   function automatic bit [63:0] absd(bit [63:0] a, bit [63:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Welford update of one slot, returns the result word this item causes
   function automatic result_type track_word(kind_type k, logic [SLOT_W-1:0] s,
                                             logic [TIME_W-1:0] t);
      result_type r;
      bit [31:0]  dt;
      bit [63:0]  x, m, v, n, den, newm, p, newv, dev;
      r = '0;
      r.status = STATUS_OK;
      case (k)
         KIND_SEND: begin
            ping_time[s] = t;
            ping_ok[s]   = 1'b1;
         end
         KIND_ARRIVE: begin
            if (!ping_ok[s]) begin
               r.status = STATUS_NO_SEND;
            end else begin
               dt = t - ping_time[s];
               x  = (dt > 32'hFFFF) ? 64'hFFFF : 64'(dt);
               r.rtt = x[15:0];
               x  = x << 8;
               if (!has_stats[s]) begin
                  avg_q8[s]    = x[MEAN_W-1:0];
                  spread_q8[s] = '0;
                  samples[s]   = 16'd1;
                  has_stats[s] = 1'b1;
               end else begin
                  m   = 64'(avg_q8[s]);
                  v   = 64'(spread_q8[s]);
                  n   = 64'(samples[s]);
                  dev = absd(x, m);
                  if (n >= 64'(cur_warmup) && dev * dev > ((64'(cur_factor) * v) << 8)) begin
                     r.status = STATUS_REJECT;
                  end else begin
                     den  = n + 1;
                     newm = (m * n + x + den / 2) / den;
                     p    = dev * absd(x, newm);
                     newv = (((p + 128) >> 8) + n * v + den / 2) / den;
                     if (newv > 64'hFF_FFFF_FFFF) newv = 64'hFF_FFFF_FFFF;
                     avg_q8[s]    = newm[MEAN_W-1:0];
                     spread_q8[s] = newv[VAR_W-1:0];
                     samples[s]   = (den >= 64'd65535) ? 16'd1 : den[15:0];
                  end
               end
            end
         end
         KIND_DELETE: begin
            r.status     = has_stats[s] ? STATUS_OK : STATUS_NO_RECORD;
            has_stats[s] = 1'b0;
         end
         default: begin
            r.status = has_stats[s] ? STATUS_OK : STATUS_NO_RECORD;
         end
      endcase
      if (has_stats[s]) begin
         r.mean     = avg_q8[s];
         r.variance = spread_q8[s];
         r.count    = samples[s];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // request side: one word, with random idle cycles ahead of it
   // ---------------------------------------------------------------------
   task automatic send_word(kind_type k, logic [SLOT_W-1:0] s, logic [TIME_W-1:0] t);
      bit took;
      while (!quiet && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= k;
      req_slot  <= s;
      req_now   <= t;
      // stall only moves on rising edges, so the value at the falling edge
      // is the one seen at the next rising edge
      forever begin
         @(negedge clock);
         took = !req_stall;
         @(posedge clock);
         if (took) break;
      end
      expected_words.push_back(track_word(k, s, t));
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      wait (expected_words.size() == 0);
      repeat (100) @(posedge clock);   // tail beyond the slowest arrive
   endtask

   task automatic csr_write(logic [PADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_FACTOR) cur_factor = data[FACTOR_W-1:0];
      else if (addr == ADDR_WARMUP) cur_warmup = data[COUNT_W-1:0];
   endtask

   task automatic set_policy(logic [FACTOR_W-1:0] f, logic [COUNT_W-1:0] w);
      drain();
      csr_write(ADDR_FACTOR, DATA_W'(f));
      csr_write(ADDR_WARMUP, DATA_W'(w));
   endtask

   // ---------------------------------------------------------------------
   // result side: random stall, check at the falling edge before acceptance
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 31);
   end

   always @(negedge clock) begin
      result_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("unexpected result word status=%0d", rsp_status);
            errors++;
         end else begin
            w = expected_words.pop_front();
            if (rsp_status !== w.status) begin
               $error("status exp %0d got %0d", w.status, rsp_status); errors++;
            end
            if (rsp_rtt !== w.rtt) begin
               $error("rtt exp %0h got %0h", w.rtt, rsp_rtt); errors++;
            end
            if (rsp_mean_q8 !== w.mean) begin
               $error("mean_q8 exp %0h got %0h", w.mean, rsp_mean_q8); errors++;
            end
            if (rsp_variance_q8 !== w.variance) begin
               $error("variance_q8 exp %0h got %0h", w.variance, rsp_variance_q8); errors++;
            end
            if (rsp_sample_count !== w.count) begin
               $error("sample_count exp %0h got %0h", w.count, rsp_sample_count); errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // corner words: empty slots, time wrap, zero and saturated rtt, delete/reuse
   task automatic test_corners;
      send_word(KIND_QUERY,  6'd0,  32'h0);              // query, no record
      send_word(KIND_ARRIVE, 6'd63, 32'hFFFF_FFFF);      // arrive, no send time
      send_word(KIND_DELETE, 6'd63, 32'h0);              // delete, no record
      send_word(KIND_SEND,   6'd5,  32'hFFFF_FFF0);
      send_word(KIND_ARRIVE, 6'd5,  32'h0000_0010);      // wraps: rtt 0x20, first sample
      send_word(KIND_ARRIVE, 6'd5,  32'hFFFF_FFF0);      // rtt 0, reuses send time
      send_word(KIND_ARRIVE, 6'd5,  32'h0001_2345);      // saturates at 0xFFFF
      send_word(KIND_QUERY,  6'd5,  32'h0);
      send_word(KIND_SEND,   6'd5,  32'h0);              // send reports stats
      send_word(KIND_DELETE, 6'd5,  32'h0);              // delete existing record
      send_word(KIND_QUERY,  6'd5,  32'h0);
      send_word(KIND_ARRIVE, 6'd5,  32'd300);            // send time kept, new first sample
      send_word(KIND_SEND,   6'd63, 32'hAAAA_5555);
      send_word(KIND_ARRIVE, 6'd63, 32'hAAAA_FFFF);
      send_word(KIND_SEND,   6'd0,  32'h5555_AAAA);
      send_word(KIND_ARRIVE, 6'd0,  32'h5556_AAA9);      // rtt 0xFFFF exactly
      send_word(KIND_ARRIVE, 6'd0,  32'h5555_AAAB);
      send_word(KIND_QUERY,  6'd63, 32'hFFFF_FFFF);
      drain();
   endtask

   // random mix over a few hot slots so counts pass the warm-up
   task automatic run_mix(int words, int hot);
      int unsigned       pick;
      logic [SLOT_W-1:0] s;
      logic [TIME_W-1:0] t;
      repeat (words) begin
         s    = ($urandom_range(9) == 0) ? SLOT_W'($urandom_range(63))
                                         : SLOT_W'($urandom_range(hot - 1));
         pick = $urandom_range(99);
         if (pick < 15 || (pick < 80 && !ping_ok[s] && $urandom_range(3) != 0)) begin
            rtt_base[s] = $urandom_range(3000, 1);
            send_word(KIND_SEND, s, $urandom);
         end else if (pick < 80) begin
            if (!ping_ok[s])                 t = $urandom;
            else if ($urandom_range(19) == 0) t = ping_time[s] + $urandom_range(200000);
            else t = ping_time[s] + rtt_base[s] + $urandom_range(40);
            send_word(KIND_ARRIVE, s, t);
         end else if (pick < 84) begin
            send_word(KIND_DELETE, s, $urandom);
         end else begin
            send_word(KIND_QUERY, s, $urandom);
         end
      end
      drain();
   endtask

   task automatic test_default_policy;
      run_mix(90, 6);
   endtask

   // strictest: zero factor, rejection from the second sample on
   task automatic test_strict_policy;
      set_policy(8'd0, 16'd1);
      run_mix(80, 6);
   endtask

   // loosest: largest factor and warm-up, no idling at all
   task automatic test_loose_policy;
      set_policy(8'hFF, 16'hFFFF);
      quiet = 1'b1;
      run_mix(80, 5);
      quiet = 1'b0;
   endtask

   // zero warm-up acts like one
   task automatic test_zero_warmup;
      set_policy(8'd1, 16'd0);
      run_mix(80, 6);
   endtask

   task automatic test_mid_policy;
      set_policy(8'd9, 16'd3);
      run_mix(90, 8);
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_kind    = KIND_SEND;
      req_slot    = '0;
      req_now     = '0;
      rsp_stall   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      cur_factor  = FACTOR_RESET;
      cur_warmup  = WARMUP_RESET;
      foreach (ping_ok[i]) begin
         ping_ok[i]   = 1'b0;
         has_stats[i] = 1'b0;
         rtt_base[i]  = 100;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corners();
      test_default_policy();
      test_strict_policy();
      test_loose_policy();
      test_zero_warmup();
      test_mid_policy();

      if (errors == 0 && expected_words.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // watchdog, well past the slowest legal run
   initial begin
      #4_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
